// File: sv/crpd_pkg.sv
// Shared constants and register indexes for the camera primary ray direction block.
package crpd_pkg;

  localparam int COORD_BITS_DEF       = 20;
  localparam int PIXEL_INDEX_BITS_DEF = 12;
  localparam int CFG_BITS             = 60;
  localparam int PIX_PORT_BITS        = 12;
  localparam int JIT_BITS             = 8;
  localparam int NORM_BITS            = 30;
  localparam int SUM_BITS             = 2 * NORM_BITS + 2;
  localparam int ROOT_STEPS           = SUM_BITS / 2;
  localparam int ROOT_BITS            = NORM_BITS + 1;
  localparam int QUOT_BITS            = 15;
  localparam int DIR_BITS             = 16;

  typedef enum logic [1:0] {
    REG_BASE = 2'd0,
    REG_COL  = 2'd1,
    REG_ROW  = 2'd2
  } reg_idx_t;

endpackage

// File: sv/crpd_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
module crpd_isqrt #(
  parameter int SIDE_BITS = 94
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [crpd_pkg::SUM_BITS-1:0]  in_sum,
  input  logic [SIDE_BITS-1:0]           in_side,
  input  logic                           en_down,
  output logic                           en_up,
  output logic                           out_valid,
  output logic [crpd_pkg::ROOT_BITS-1:0] out_root,
  output logic [SIDE_BITS-1:0]           out_side
);

  localparam int N  = crpd_pkg::ROOT_STEPS;
  localparam int SB = crpd_pkg::SUM_BITS;

  logic          vld  [N];
  logic          en   [N];
  logic [SB-1:0] rem  [N];
  logic [SB-1:0] res  [N];
  logic [SIDE_BITS-1:0] side [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [SB-1:0] BIT = SB'(1) << (SB - 2 - 2 * k);
    logic [SB-1:0] rem_in;
    logic [SB-1:0] res_in;
    logic [SIDE_BITS-1:0] side_in;
    logic          v_in;
    logic [SB-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = in_sum;
      assign res_in  = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign res_in  = res[k-1];
      assign side_in = side[k-1];
      assign v_in    = vld[k-1];
    end

    if (k == N - 1) begin : g_last_en
      assign en[k] = !vld[k] || en_down;
    end else begin : g_mid_en
      assign en[k] = !vld[k] || en[k+1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        side[k] <= side_in;
        if (rem_in >= trial) begin
          rem[k] <= rem_in - trial;
          res[k] <= (res_in >> 1) + BIT;
        end else begin
          rem[k] <= rem_in;
          res[k] <= res_in >> 1;
        end
      end
    end
  end

  assign en_up     = en[0];
  assign out_valid = vld[N-1];
  assign out_root  = crpd_pkg::ROOT_BITS'(res[N-1]);
  assign out_side  = side[N-1];

endmodule

// File: sv/camera_primary_ray_direction.sv
// Top level: pinhole camera primary ray direction, pipelined form and normalise.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata: pixel_col, pixel_row, jitter_col, jitter_row
//  m_*      out  m_tvalid/m_tready    m_tdata: dir_x, dir_y, dir_z; m_tuser: degenerate
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One transfer per cycle in and out when m_tready does not stall; 7 front stages (products, sum,
// max, leading one, shift, squares, sum of squares), 31 square root stages, 15 divider
// stages and the output register. Reset clears all valid bits and the three registers.
// Each stage advances when it is empty or the next one advances, so a stall on m_tready
// holds every item in place and bubbles are squeezed out.
module camera_primary_ray_direction #(
  parameter int COORD_BITS       = crpd_pkg::COORD_BITS_DEF,
  parameter int PIXEL_INDEX_BITS = crpd_pkg::PIXEL_INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [39:0]                      s_tdata,   // pixel_col, pixel_row, jitter_col, jitter_row
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [3*crpd_pkg::DIR_BITS-1:0]  m_tdata,   // dir_x, dir_y, dir_z
  output logic                             m_tuser,   // degenerate
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [crpd_pkg::CFG_BITS-1:0]    cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int PB   = PIXEL_INDEX_BITS;
  localparam int TB   = PB + crpd_pkg::JIT_BITS;
  localparam int PW   = CB + TB + 1;
  localparam int DW   = PW + 2;
  localparam int PSW  = $clog2(DW);
  localparam int MW   = crpd_pkg::NORM_BITS;
  localparam int SB   = crpd_pkg::SUM_BITS;
  localparam int RB   = crpd_pkg::ROOT_BITS;
  localparam int QB   = crpd_pkg::QUOT_BITS;
  localparam int NW   = MW + QB + 1;
  localparam int OB   = crpd_pkg::DIR_BITS;
  localparam int SIDE = 3 * MW + 4;
  localparam int NF   = 7;

  logic [crpd_pkg::CFG_BITS-1:0] base_vector, column_step, row_step;
  logic [3*CB-1:0] base_x, col_x, row_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_vector <= '0;
      column_step <= '0;
      row_step    <= '0;
    end else if (cfg_valid) begin
      unique case (crpd_pkg::reg_idx_t'(cfg_index))
        crpd_pkg::REG_BASE: base_vector <= cfg_data;
        crpd_pkg::REG_COL:  column_step <= cfg_data;
        crpd_pkg::REG_ROW:  row_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign base_x = (3*CB)'(base_vector);
  assign col_x  = (3*CB)'(column_step);
  assign row_x  = (3*CB)'(row_step);

  // input fields
  logic [15:0] col_w, row_w;
  logic [TB-1:0] tc, tr;
  assign col_w = 16'(s_tdata[11:0]);
  assign row_w = 16'(s_tdata[23:12]);
  assign tc = {col_w[PB-1:0], s_tdata[31:24]};
  assign tr = {row_w[PB-1:0], s_tdata[39:32]};

  // front stage control
  logic v_f [NF];
  logic en_f [NF];
  logic sq_en_up;

  for (genvar k = 0; k < NF; k++) begin : g_fen
    if (k == NF - 1) begin : g_l
      assign en_f[k] = !v_f[k] || sq_en_up;
    end else begin : g_m
      assign en_f[k] = !v_f[k] || en_f[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NF; k++) v_f[k] <= 1'b0;
    end else begin
      if (en_f[0]) v_f[0] <= s_tvalid;
      for (int k = 1; k < NF; k++) if (en_f[k]) v_f[k] <= v_f[k-1];
    end
  end

  assign s_tready = en_f[0];

  // stage 0: products
  logic signed [PW-1:0] pc0 [3];
  logic signed [PW-1:0] pr0 [3];
  logic signed [CB-1:0] bs0 [3];

  always_ff @(posedge clk) begin
    if (en_f[0]) begin
      for (int k = 0; k < 3; k++) begin
        pc0[k] <= PW'($signed(col_x[k*CB +: CB])) * PW'($signed({1'b0, tc}));
        pr0[k] <= PW'($signed(row_x[k*CB +: CB])) * PW'($signed({1'b0, tr}));
        bs0[k] <= $signed(base_x[k*CB +: CB]);
      end
    end
  end

  // stage 1: sum, sign and magnitude
  logic [DW-1:0] mag1 [3];
  logic [2:0]    neg1;

  always_ff @(posedge clk) begin
    if (en_f[1]) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [DW-1:0] d;
        d = (DW'(bs0[k]) <<< 8) + DW'(pc0[k]) + DW'(pr0[k]);
        neg1[k] <= d[DW-1];
        mag1[k] <= d[DW-1] ? DW'(-d) : DW'(d);
      end
    end
  end

  // stage 2: largest magnitude
  logic [DW-1:0] mag2 [3];
  logic [DW-1:0] mx2;
  logic [2:0]    neg2;
  logic [DW-1:0] mx01;

  assign mx01 = (mag1[0] > mag1[1]) ? mag1[0] : mag1[1];

  always_ff @(posedge clk) begin
    if (en_f[2]) begin
      mag2 <= mag1;
      neg2 <= neg1;
      mx2  <= (mx01 > mag1[2]) ? mx01 : mag1[2];
    end
  end

  // stage 3: leading one and shift amount
  logic [DW-1:0]  mag3 [3];
  logic [2:0]     neg3;
  logic           deg3, right3;
  logic [PSW-1:0] amt3;
  logic [PSW-1:0] msb;

  always_comb begin
    msb = '0;
    for (int i = 0; i < DW; i++) begin
      if (mx2[i]) msb = PSW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en_f[3]) begin
      mag3   <= mag2;
      neg3   <= neg2;
      deg3   <= (mx2 == '0);
      right3 <= (msb > PSW'(MW - 1));
      amt3   <= (msb > PSW'(MW - 1)) ? msb - PSW'(MW - 1) : PSW'(MW - 1) - msb;
    end
  end

  // stage 4: scale
  logic [MW-1:0] m4 [3];
  logic [2:0]    neg4;
  logic          deg4;

  always_ff @(posedge clk) begin
    if (en_f[4]) begin
      for (int k = 0; k < 3; k++) begin
        m4[k] <= right3 ? MW'(mag3[k] >> amt3) : MW'(mag3[k] << amt3);
      end
      neg4 <= neg3;
      deg4 <= deg3;
    end
  end

  // stage 5: squares
  logic [2*MW-1:0] sq5 [3];
  logic [MW-1:0]   m5 [3];
  logic [2:0]      neg5;
  logic            deg5;

  always_ff @(posedge clk) begin
    if (en_f[5]) begin
      for (int k = 0; k < 3; k++) sq5[k] <= (2*MW)'(m4[k]) * (2*MW)'(m4[k]);
      m5   <= m4;
      neg5 <= neg4;
      deg5 <= deg4;
    end
  end

  // stage 6: sum of squares
  logic [SB-1:0]   sum6;
  logic [SIDE-1:0] side6;

  always_ff @(posedge clk) begin
    if (en_f[6]) begin
      sum6  <= SB'(sq5[0]) + SB'(sq5[1]) + SB'(sq5[2]);
      side6 <= {deg5, neg5, m5[2], m5[1], m5[0]};
    end
  end

  // square root
  logic            v_sq;
  logic [RB-1:0]   root_sq;
  logic [SIDE-1:0] side_sq;
  logic            en_d [QB];

  crpd_isqrt #(
    .SIDE_BITS(SIDE)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_f[NF-1]),
    .in_sum   (sum6),
    .in_side  (side6),
    .en_down  (en_d[0]),
    .en_up    (sq_en_up),
    .out_valid(v_sq),
    .out_root (root_sq),
    .out_side (side_sq)
  );

  // divider: one quotient bit per stage for each component
  logic          v_d   [QB];
  logic [NW-1:0] rem_d [QB][3];
  logic [QB-1:0] q_d   [QB][3];
  logic [NW-1:0] dv_d  [QB];
  logic [2:0]    neg_d [QB];
  logic          deg_d [QB];
  logic          en_out;

  assign en_out = !m_tvalid || m_tready;

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [NW-1:0] rem_in [3];
    logic [QB-1:0] q_in   [3];
    logic [NW-1:0] dv_in;
    logic [2:0]    neg_in;
    logic          deg_in, v_in;
    logic [NW-1:0] trial;

    if (j == 0) begin : g_first
      for (genvar k = 0; k < 3; k++) begin : g_n
        assign rem_in[k] = (NW'(side_sq[k*MW +: MW]) << QB) + NW'(root_sq);
        assign q_in[k]   = '0;
      end
      assign dv_in  = NW'({root_sq, 1'b0});
      assign neg_in = side_sq[3*MW +: 3];
      assign deg_in = side_sq[3*MW+3];
      assign v_in   = v_sq;
    end else begin : g_next
      assign rem_in = rem_d[j-1];
      assign q_in   = q_d[j-1];
      assign dv_in  = dv_d[j-1];
      assign neg_in = neg_d[j-1];
      assign deg_in = deg_d[j-1];
      assign v_in   = v_d[j-1];
    end

    if (j == QB - 1) begin : g_le
      assign en_d[j] = !v_d[j] || en_out;
    end else begin : g_me
      assign en_d[j] = !v_d[j] || en_d[j+1];
    end

    assign trial = dv_in << (QB - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[j] <= 1'b0;
      end else if (en_d[j]) begin
        v_d[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_d[j]) begin
        for (int k = 0; k < 3; k++) begin
          if (rem_in[k] >= trial) begin
            rem_d[j][k] <= rem_in[k] - trial;
            q_d[j][k]   <= q_in[k] | (QB'(1) << (QB - 1 - j));
          end else begin
            rem_d[j][k] <= rem_in[k];
            q_d[j][k]   <= q_in[k];
          end
        end
        dv_d[j]  <= dv_in;
        neg_d[j] <= neg_in;
        deg_d[j] <= deg_in;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v_d[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      for (int k = 0; k < 3; k++) begin
        if (deg_d[QB-1]) begin
          m_tdata[k*OB +: OB] <= '0;
        end else if (neg_d[QB-1][k]) begin
          m_tdata[k*OB +: OB] <= -OB'(q_d[QB-1][k]);
        end else begin
          m_tdata[k*OB +: OB] <= OB'(q_d[QB-1][k]);
        end
      end
      m_tuser <= deg_d[QB-1];
    end
  end

  // checks
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result with nonzero direction");

  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    v_f[5] && !deg5 |-> (m5[0][MW-1] || m5[1][MW-1] || m5[2][MW-1]))
    else $error("scaled maximum not in normal range");

  a_root_nz: assert property (@(posedge clk) disable iff (rst)
    v_sq && !side_sq[3*MW+3] |-> root_sq != '0)
    else $error("zero root for nonzero vector");

  a_range: assert property (@(posedge clk) disable iff (rst)
    v_d[QB-1] |-> (q_d[QB-1][0] <= QB'(16384) && q_d[QB-1][1] <= QB'(16384)
                   && q_d[QB-1][2] <= QB'(16384)) || deg_d[QB-1])
    else $error("quotient above unit length");

endmodule

// File: tb/camera_primary_ray_direction_tb.sv
// Testbench for the camera primary ray direction block: self-checking stream regression.
`timescale 1ns / 1ps
module camera_primary_ray_direction_tb;

  localparam int CB = crpd_pkg::COORD_BITS_DEF;
  localparam int PB = crpd_pkg::PIXEL_INDEX_BITS_DEF;
  localparam int CFGW = crpd_pkg::CFG_BITS;
  localparam int LATENCY = 54;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        degen;
  } ray_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  crpd_pkg::reg_idx_t cfg_index = crpd_pkg::REG_BASE;
  logic [CFGW-1:0] cfg_data = '0;

  logic [CFGW-1:0] cam_base, cam_col_step, cam_row_step;
  ray_t rays_due[$];
  int mismatches = 0;
  int unexpected = 0;
  int rays_checked = 0;
  int degenerate_seen = 0;
  int items_sent = 0;
  longint cycles = 0;
  bit stall_mode = 1'b0;

  camera_primary_ray_direction u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint comp_of(logic [CFGW-1:0] r, int k);
    logic [CB-1:0] v;
    v = r[k*CB +: CB];
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_dir(logic [11:0] col, logic [11:0] row,
                                     logic [7:0] jc, logic [7:0] jr);
    longint tc, tr, d;
    longint unsigned mag[3];
    longint unsigned mx, s, r, q;
    bit neg[3];
    logic [15:0] o[3];
    ray_t res;
    tc = longint'({col[PB-1:0], jc});
    tr = longint'({row[PB-1:0], jr});
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      d = comp_of(cam_base, k) * 256 + tc * comp_of(cam_col_step, k)
        + tr * comp_of(cam_row_step, k);
      neg[k] = d < 0;
      mag[k] = neg[k] ? longint'(-d) : longint'(d);
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      res = '0;
      res.degen = 1'b1;
      return res;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    r = int_sqrt(s);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << 15) + r) / (2 * r);
      if (neg[k]) q = -q;
      o[k] = q[15:0];
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    res.degen = 1'b0;
    return res;
  endfunction

  function automatic logic [CFGW-1:0] pack_vec(longint x, longint y, longint z);
    logic [CFGW-1:0] v;
    v = '0;
    v[0 +: CB] = x[CB-1:0];
    v[CB +: CB] = y[CB-1:0];
    v[2*CB +: CB] = z[CB-1:0];
    return v;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("camera_primary_ray_direction regression: fail");
      $finish;
    end
  end

  // receiver: stall on a rotating pattern, sometimes always ready
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (!stall_mode) m_tready <= 1'b1;
    else m_tready <= (cycles % 11 < 7) && ($urandom_range(0, 5) != 0);
  end

  always @(posedge clk) begin
    ray_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
      if (rays_due.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %h", got);
      end else begin
        want = rays_due.pop_front();
        rays_checked++;
        if (got.degen) degenerate_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected x=%0d y=%0d z=%0d deg=%b,",
                      " got x=%0d y=%0d z=%0d deg=%b"},
                     $signed(want.x), $signed(want.y), $signed(want.z), want.degen,
                     $signed(got.x), $signed(got.y), $signed(got.z), got.degen);
        end
      end
    end
  end

  task automatic write_reg(crpd_pkg::reg_idx_t idx, logic [CFGW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      crpd_pkg::REG_BASE: cam_base = val;
      crpd_pkg::REG_COL:  cam_col_step = val;
      crpd_pkg::REG_ROW:  cam_row_step = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (rays_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_camera(logic [CFGW-1:0] b, logic [CFGW-1:0] c,
                            logic [CFGW-1:0] r);
    drain();
    write_reg(crpd_pkg::REG_BASE, b);
    write_reg(crpd_pkg::REG_COL, c);
    write_reg(crpd_pkg::REG_ROW, r);
  endtask

  // send one pixel; with keep_valid set, hold valid across back-to-back transfers
  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [7:0] jc,
                            logic [7:0] jr, bit keep_valid);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {jr, jc, row, col};
    do @(posedge clk); while (!s_tready);
    rays_due = {rays_due, trace_dir(col, row, jc, jr)};
    items_sent++;
    if (!keep_valid) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic send_burst_random(int n);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++)
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   i != burst - 1);
      left -= burst;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  task automatic test_reset_degenerate();
    send_pixel(0, 0, 0, 0, 0);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 0);
  endtask

  task automatic test_directed_extremes();
    set_camera(pack_vec(-12345, 6789, -65536), pack_vec(64, 0, 0), pack_vec(0, -64, 0));
    send_pixel(0, 0, 0, 0, 1);
    send_pixel(12'hFFF, 0, 8'hFF, 0, 1);
    send_pixel(0, 12'hFFF, 0, 8'hFF, 1);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 1);
    send_pixel(12'hAAA, 12'h555, 8'hAA, 8'h55, 1);
    send_pixel(12'h555, 12'hAAA, 8'h55, 8'hAA, 0);
    // extreme components: most negative and most positive
    set_camera(pack_vec(-(1 <<< (CB-1)), (1 <<< (CB-1)) - 1, -(1 <<< (CB-1))),
               pack_vec((1 <<< (CB-1)) - 1, -(1 <<< (CB-1)), (1 <<< (CB-1)) - 1),
               pack_vec(-(1 <<< (CB-1)), -(1 <<< (CB-1)), (1 <<< (CB-1)) - 1));
    send_pixel(0, 0, 0, 0, 1);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 1);
    send_pixel(12'hFFF, 0, 0, 8'hFF, 0);
    // axis aligned and small vectors
    set_camera(pack_vec(0, 0, -256), pack_vec(1, 0, 0), pack_vec(0, 1, 0));
    send_pixel(0, 0, 0, 0, 1);
    send_pixel(0, 0, 1, 0, 1);
    send_pixel(7, 3, 8'h80, 8'h80, 0);
    set_camera(pack_vec(-256, 0, 0), pack_vec(1, 0, 0), '0);
    send_pixel(1, 0, 0, 0, 1);
    send_pixel(0, 9, 0, 0, 1);
    send_pixel(1, 5, 0, 0, 0);
    // all register bits set: every component is -1
    set_camera({CFGW{1'b1}}, '0, '0);
    send_pixel(3, 3, 3, 3, 0);
  endtask

  task automatic test_random_cameras();
    for (int p = 0; p < 6; p++) begin
      stall_mode = p[0];
      set_camera(CFGW'({$urandom, $urandom}), CFGW'({$urandom, $urandom}),
                 CFGW'({$urandom, $urandom}));
      send_burst_random(70);
    end
  endtask

  task automatic test_typical_viewport();
    longint sc;
    for (int p = 0; p < 3; p++) begin
      stall_mode = !p[0];
      sc = $urandom_range(1, 64);
      set_camera(pack_vec(-sc * 960, sc * 540, -longint'($urandom_range(1, 500000))),
                 pack_vec(sc, 0, 0), pack_vec(0, -sc, 0));
      send_burst_random(70);
    end
  endtask

  initial begin
    cam_base = '0;
    cam_col_step = '0;
    cam_row_step = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_degenerate();
    test_directed_extremes();
    test_random_cameras();
    test_typical_viewport();
    stall_mode = 1'b1;
    set_camera('0, '0, '0);
    send_burst_random(10);
    drain();
    $display("covered %0d pixels, %0d rays checked, %0d degenerate, under varied cameras",
             items_sent, rays_checked, degenerate_seen);
    $display("with random bursts and output stalls; %0d mismatches", mismatches);
    if (mismatches == 0 && rays_due.size() == 0)
      $display("camera_primary_ray_direction regression: pass");
    else
      $display("camera_primary_ray_direction regression: fail");
    $finish;
  end
endmodule
